// ===== rtl/core/itew_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the integer to english word tokens unit
package itew_pkg;

  localparam int VALUE_W   = 31;
  localparam int WORD_W    = 5;
  localparam int DIGITS    = 10;
  localparam int BCD_W     = DIGITS * 4;

  // binary to decimal conversion: four shift steps per cycle over a 32-bit word
  localparam int CONV_BITS      = 32;
  localparam int STEPS_PER_CYC  = 4;
  localparam int CONV_CYCLES    = CONV_BITS / STEPS_PER_CYC;
  localparam int CONV_CNT_W     = $clog2(CONV_CYCLES);

  // word slots: four groups of five slots, then the lone zero slot
  localparam int GROUPS        = 4;
  localparam int SLOTS_PER_GRP = 5;
  localparam int SLOTS         = GROUPS * SLOTS_PER_GRP + 1;
  localparam int SLOT_IDX_W    = $clog2(SLOTS);

  typedef logic [BCD_W-1:0]  bcd_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0]        digit_t;

  localparam word_t W_ZERO     = 5'd0;
  localparam word_t W_TEEN     = 5'd10;
  localparam word_t W_TENS     = 5'd18;
  localparam word_t W_HUNDRED  = 5'd28;
  localparam word_t W_THOUSAND = 5'd29;
  localparam word_t W_MILLION  = 5'd30;
  localparam word_t W_BILLION  = 5'd31;

  function automatic word_t scale_word(input logic [1:0] grp);
    word_t w;
    begin
      unique case (grp)
        2'd0:    w = W_BILLION;
        2'd1:    w = W_MILLION;
        2'd2:    w = W_THOUSAND;
        default: w = W_ZERO;
      endcase
      return w;
    end
  endfunction

endpackage

// ===== rtl/core/itew_front.sv =====
`timescale 1ns / 1ps
// front end: accepts a value and converts it to ten decimal digits
module itew_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [itew_pkg::VALUE_W-1:0]  value,
  output logic                          push,
  input  logic                          full,
  output itew_pkg::bcd_t                bcd
);

  function automatic itew_pkg::bcd_t dabble(input itew_pkg::bcd_t b, input logic bit_in);
    itew_pkg::bcd_t r;
    begin
      r = b;
      for (int k = 0; k < itew_pkg::DIGITS; k++) begin
        if (r[k*4 +: 4] >= 4'd5) begin
          r[k*4 +: 4] = r[k*4 +: 4] + 4'd3;
        end
      end
      return {r[itew_pkg::BCD_W-2:0], bit_in};
    end
  endfunction

  logic                              busy;
  logic                              done;
  logic [itew_pkg::CONV_CNT_W-1:0]   cnt;
  logic [itew_pkg::CONV_BITS-1:0]    shreg;
  itew_pkg::bcd_t                    bcd_next;

  always_comb begin
    bcd_next = bcd;
    for (int k = 0; k < itew_pkg::STEPS_PER_CYC; k++) begin
      bcd_next = dabble(bcd_next, shreg[itew_pkg::CONV_BITS-1-k]);
    end
  end

  assign push     = done && !full;
  assign in_ready = !busy || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy && !done) begin
      cnt <= cnt + 1'b1;
      if (cnt == itew_pkg::CONV_CNT_W'(itew_pkg::CONV_CYCLES - 1)) begin
        done <= 1'b1;
      end
    end else if (push) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      shreg <= itew_pkg::CONV_BITS'(value);
      bcd   <= '0;
    end else if (busy && !done) begin
      shreg <= shreg << itew_pkg::STEPS_PER_CYC;
      bcd   <= bcd_next;
    end
  end

endmodule

// ===== rtl/core/itew_fifo.sv =====
`timescale 1ns / 1ps
// short digit queue between front and back
module itew_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  itew_pkg::bcd_t  wdata,
  output logic            full,
  input  logic            pop,
  output itew_pkg::bcd_t  rdata,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itew_pkg::bcd_t    mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/itew_back.sv =====
`timescale 1ns / 1ps
// back end: walks the digit groups and emits one word per transaction
module itew_back (
  input  logic                          clk,
  input  logic                          rst,
  input  itew_pkg::bcd_t                head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output itew_pkg::word_t               word,
  output logic                          last
);

  logic [itew_pkg::BCD_W+7:0]        padded;
  logic [itew_pkg::SLOTS-1:0]        slot_en;
  itew_pkg::word_t                   slot_word [itew_pkg::SLOTS];
  logic [itew_pkg::SLOTS-1:0]        sent;
  logic [itew_pkg::SLOTS-1:0]        remaining;
  logic [itew_pkg::SLOTS-1:0]        onehot;
  logic [itew_pkg::SLOT_IDX_W-1:0]   sel;
  logic                              last_sel;
  logic                              go;
  itew_pkg::digit_t                  h;
  itew_pkg::digit_t                  t;
  itew_pkg::digit_t                  o;
  int                                base;

  // slot words and enables for the digits at the head of the queue
  always_comb begin
    padded = {8'b0, head};
    for (int g = 0; g < itew_pkg::GROUPS; g++) begin
      base = 3 * (itew_pkg::GROUPS - 1 - g);
      o = padded[base*4 +: 4];
      t = padded[(base+1)*4 +: 4];
      h = padded[(base+2)*4 +: 4];
      slot_en[g*5]       = (h != 4'd0);
      slot_word[g*5]     = {1'b0, h};
      slot_en[g*5+1]     = (h != 4'd0);
      slot_word[g*5+1]   = itew_pkg::W_HUNDRED;
      slot_en[g*5+2]     = (t != 4'd0);
      slot_word[g*5+2]   = (t == 4'd1) ? itew_pkg::W_TEEN + {1'b0, o}
                                       : itew_pkg::W_TENS + {1'b0, t};
      slot_en[g*5+3]     = (t != 4'd1) && (o != 4'd0);
      slot_word[g*5+3]   = {1'b0, o};
      slot_en[g*5+4]     = (g < itew_pkg::GROUPS - 1) && ((h | t | o) != 4'd0);
      slot_word[g*5+4]   = itew_pkg::scale_word(2'(g));
    end
    slot_en[itew_pkg::SLOTS-1]   = (head == '0);
    slot_word[itew_pkg::SLOTS-1] = itew_pkg::W_ZERO;
  end

  // lowest pending slot goes next
  always_comb begin
    remaining = slot_en & ~sent;
    sel = '0;
    for (int i = itew_pkg::SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        sel = itew_pkg::SLOT_IDX_W'(i);
      end
    end
    onehot   = itew_pkg::SLOTS'(1) << sel;
    last_sel = ((remaining & ~onehot) == '0);
  end

  assign go  = !empty && (!out_valid || out_ready);
  assign pop = go && last_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else if (go) begin
      out_valid <= 1'b1;
      sent      <= last_sel ? '0 : (sent | onehot);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      word <= slot_word[sel];
      last <= last_sel;
    end
  end

endmodule

// ===== rtl/core/integer_to_english_word_tokens_unit.sv =====
`timescale 1ns / 1ps
// Spells a 31-bit unsigned value as English word codes, one word per output
// transaction with last set on the final word. The front end converts the value to
// decimal with a shift-and-add-three unit, four bits per cycle; the back end
// emits one word per cycle while the queue holds digits and out_ready is high,
// one to sixteen per value. A queue of QUEUE_DEPTH converted values sits between
// them, so the front end can take a new value while the back end emits the last.
// The first word is registered after the conversion and the queue write.
module integer_to_english_word_tokens_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [itew_pkg::VALUE_W-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itew_pkg::WORD_W-1:0]   word,
  output logic                          last
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  itew_pkg::bcd_t  q_wdata;
  itew_pkg::bcd_t  q_rdata;

  itew_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .push     (q_push),
    .full     (q_full),
    .bcd      (q_wdata)
  );

  itew_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  itew_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_rdata),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word      (word),
    .last      (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_zero_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (word == itew_pkg::W_ZERO) |-> last)
    else $error("zero word not alone");

endmodule
